@@ sv/triangle_edge_basis_eval_unit_macros.svh @@
// Assertion macros for the edge basis evaluation unit checkers.
// Each macro expects clk in the scope of its use; the first two also expect rst_n.
`ifndef TRIANGLE_EDGE_BASIS_EVAL_UNIT_MACROS_SVH
`define TRIANGLE_EDGE_BASIS_EVAL_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define TEBE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tebe_chk: assertion failed");

// next-cycle implication, off while in reset
`define TEBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tebe_chk: assertion failed");

// next-cycle implication, active through reset
`define TEBE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tebe_chk: assertion failed");

`endif

@@ sv/tebe_pkg.sv @@
// Shared constants and codes for the edge basis evaluation unit.
// No dependencies.
package tebe_pkg;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 32;
  localparam int Q_BITS = OUT_W + 1;

  localparam logic CMD_VALUE = 1'b0;
  localparam logic CMD_CURL  = 1'b1;

  localparam logic [1:0] EDGE_12 = 2'd0;
  localparam logic [1:0] EDGE_20 = 2'd1;
  localparam logic [1:0] EDGE_01 = 2'd2;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

@@ sv/tebe_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
// Depends on tebe_pkg.
interface tebe_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [1:0]                   edge_req;
  logic [tebe_pkg::IN_W-1:0]    px, py, ax, ay, bx, by, cx, cy;

  modport source (output valid, command, edge_req, px, py, ax, ay, bx, by, cx, cy,
                  input ready);
  modport sink (input valid, command, edge_req, px, py, ax, ay, bx, by, cx, cy,
                output ready);
endinterface

interface tebe_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [tebe_pkg::OUT_W-1:0] out_first;
  logic signed [tebe_pkg::OUT_W-1:0] out_second;
  logic                            degenerate;
  logic                            saturated;

  modport source (output valid, out_first, out_second, degenerate, saturated,
                  input ready);
  modport sink (input valid, out_first, out_second, degenerate, saturated,
                output ready);
endinterface

@@ sv/tebe_front.sv @@
// Front stages: coordinate differences, area and squared edge length.
// Three register stages; depends on tebe_pkg.
module tebe_front #(
  parameter int CB = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [1:0]                 in_edge,
  input  logic [tebe_pkg::IN_W-1:0]  in_px, in_py, in_ax, in_ay,
  input  logic [tebe_pkg::IN_W-1:0]  in_bx, in_by, in_cx, in_cy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_cmd,
  output logic                       out_zero,
  output logic                       out_lneg,
  output logic signed [CB:0]         out_ex,
  output logic signed [CB:0]         out_ey,
  output logic signed [2*CB+2:0]     out_area,
  output logic [2*CB+1:0]            out_s
);
  localparam int DW = CB + 1;
  localparam int MW = 2 * DW;
  localparam int AW = MW + 1;

  function automatic logic signed [DW-1:0] crd(input logic [tebe_pkg::IN_W-1:0] v);
    logic [CB-1:0] t;
    t = CB'(v);
    return DW'(signed'(t));
  endfunction

  logic [2:0] v_r;
  logic [3:0] en;

  assign en[3] = out_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready = en[0];

  logic signed [DW-1:0] px_c, py_c, ax_c, ay_c, bx_c, by_c, cx_c, cy_c;
  logic signed [DW-1:0] l0_nxt, l1_nxt, ex_nxt, ey_nxt;

  assign px_c = crd(in_px);
  assign py_c = crd(in_py);
  assign ax_c = crd(in_ax);
  assign ay_c = crd(in_ay);
  assign bx_c = crd(in_bx);
  assign by_c = crd(in_by);
  assign cx_c = crd(in_cx);
  assign cy_c = crd(in_cy);

  always_comb begin
    case (in_edge)
      tebe_pkg::EDGE_20: begin
        l0_nxt = cx_c - ax_c;
        l1_nxt = cy_c - ay_c;
        ex_nxt = px_c - bx_c;
        ey_nxt = by_c - py_c;
      end
      tebe_pkg::EDGE_01: begin
        l0_nxt = ax_c - bx_c;
        l1_nxt = ay_c - by_c;
        ex_nxt = px_c - cx_c;
        ey_nxt = cy_c - py_c;
      end
      default: begin
        l0_nxt = bx_c - cx_c;
        l1_nxt = by_c - cy_c;
        ex_nxt = px_c - ax_c;
        ey_nxt = ay_c - py_c;
      end
    endcase
  end

  // stage 1
  logic                 cmd1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r, l0_r, l1_r, ex1_r, ey1_r;

  // stage 2
  logic                 cmd2_r, lneg2_r;
  logic signed [MW-1:0] p1_r, p2_r, s0_r, s1_r;
  logic signed [DW-1:0] ex2_r, ey2_r;
  logic [DW-1:0]        a0_c, a1_c;
  logic                 lneg_nxt;

  assign a0_c     = l0_r[DW-1] ? DW'(-l0_r) : DW'(l0_r);
  assign a1_c     = l1_r[DW-1] ? DW'(-l1_r) : DW'(l1_r);
  assign lneg_nxt = (a0_c > a1_c) ? l0_r[DW-1] : l1_r[DW-1];

  // stage 3
  logic                 cmd3_r, lneg3_r, zero3_r;
  logic signed [AW-1:0] area_r;
  logic [MW-1:0]        s_r;
  logic signed [DW-1:0] ex3_r, ey3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd1_r <= in_cmd;
      dx1_r  <= bx_c - ax_c;
      dy1_r  <= by_c - ay_c;
      dx2_r  <= cx_c - ax_c;
      dy2_r  <= cy_c - ay_c;
      l0_r   <= l0_nxt;
      l1_r   <= l1_nxt;
      ex1_r  <= ex_nxt;
      ey1_r  <= ey_nxt;
    end
    if (en[1]) begin
      cmd2_r  <= cmd1_r;
      lneg2_r <= lneg_nxt;
      p1_r    <= dx1_r * dy2_r;
      p2_r    <= dy1_r * dx2_r;
      s0_r    <= l0_r * l0_r;
      s1_r    <= l1_r * l1_r;
      ex2_r   <= ex1_r;
      ey2_r   <= ey1_r;
    end
    if (en[2]) begin
      cmd3_r  <= cmd2_r;
      lneg3_r <= lneg2_r;
      zero3_r <= (p1_r == p2_r);
      area_r  <= AW'(p1_r) - AW'(p2_r);
      s_r     <= $unsigned(s0_r) + $unsigned(s1_r);
      ex3_r   <= ex2_r;
      ey3_r   <= ey2_r;
    end
  end

  assign out_valid = v_r[2];
  assign out_cmd   = cmd3_r;
  assign out_zero  = zero3_r;
  assign out_lneg  = lneg3_r;
  assign out_ex    = ex3_r;
  assign out_ey    = ey3_r;
  assign out_area  = area_r;
  assign out_s     = s_r;
endmodule

@@ sv/tebe_sqrt.sv @@
// Pipelined floor square root, one result bit per register stage.
// Carries an opaque sideband vector alongside; no package use.
module tebe_sqrt #(
  parameter int CB     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2*CB+1:0]   in_s,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CB:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);
  localparam int SW = 2 * CB + 2;
  localparam int RW = CB + 1;
  localparam int NS = RW;

  logic [NS-1:0]     v_r;
  logic [NS-1:0]     vin;
  logic [NS:0]       en;
  logic [SW-1:0]     rem_r    [NS];
  logic [SW-1:0]     rem_nxt  [NS];
  logic [RW-1:0]     q_r      [NS];
  logic [RW-1:0]     q_nxt    [NS];
  logic [SIDE_W-1:0] side_r   [NS];
  logic [SIDE_W-1:0] side_nxt [NS];

  assign en[NS]   = out_ready;
  assign in_ready = en[0];

  for (genvar g = 0; g < NS; g++) begin : g_stg
    localparam int B = RW - 1 - g;
    logic [SW-1:0] rem_i;
    logic [RW-1:0] q_i;
    logic [SW+1:0] trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_i       = in_s;
      assign q_i         = '0;
      assign side_nxt[g] = in_side;
      assign vin[g]      = in_valid;
    end else begin : g_next
      assign rem_i       = rem_r[g-1];
      assign q_i         = q_r[g-1];
      assign side_nxt[g] = side_r[g-1];
      assign vin[g]      = v_r[g-1];
    end

    assign trial      = ((SW+2)'(q_i) << (B + 1)) + ((SW+2)'(1) << (2 * B));
    assign ge         = (SW+2)'(rem_i) >= trial;
    assign rem_nxt[g] = ge ? rem_i - trial[SW-1:0] : rem_i;
    assign q_nxt[g]   = ge ? (q_i | (RW'(1) << B)) : q_i;
    assign en[g]      = !v_r[g] || en[g+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_r[i] <= vin[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (en[i]) begin
        rem_r[i]  <= rem_nxt[i];
        q_r[i]    <= q_nxt[i];
        side_r[i] <= side_nxt[i];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = q_r[NS-1];
  assign out_side  = side_r[NS-1];
endmodule

@@ sv/tebe_div.sv @@
// Scaling, pipelined rounded division of two numerators by the area,
// and saturation to the result range. Depends on tebe_pkg.
module tebe_div #(
  parameter int CB = 32,
  parameter int FB = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [CB:0]                        in_root,
  input  logic                               in_lneg,
  input  logic                               in_cmd,
  input  logic                               in_zero,
  input  logic signed [CB:0]                 in_ex,
  input  logic signed [CB:0]                 in_ey,
  input  logic signed [2*CB+2:0]             in_area,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tebe_pkg::OUT_W-1:0]  out_first,
  output logic signed [tebe_pkg::OUT_W-1:0]  out_second,
  output logic                               out_degen,
  output logic                               out_sat
);
  localparam int DW  = CB + 1;
  localparam int AW  = 2 * DW + 1;
  localparam int RW  = CB + 1;
  localparam int LW  = RW + 1;
  localparam int PW  = LW + DW;
  localparam int NVW = 2 * CB + 2 + FB;
  localparam int NCW = CB + 1 + 2 * FB;
  localparam int NW  = (NVW > NCW) ? NVW : NCW;
  localparam int QB  = tebe_pkg::Q_BITS;
  localparam int OW  = tebe_pkg::OUT_W;
  localparam int XA  = NW + 2;
  localparam int XB  = AW + QB + 1;
  localparam int XW  = ((XA > XB) ? XA : XB) + 1;
  localparam int SM  = 0;
  localparam int SA  = 1;
  localparam int SB  = 2;
  localparam int SC  = 3;
  localparam int SQ  = 4;
  localparam int SF  = SQ + QB;
  localparam int NS  = SF + 1;

  typedef struct packed {
    logic [XW-1:0] ra;
    logic [XW-1:0] rb;
    logic [XW-1:0] d;
    logic [QB-1:0] qa;
    logic [QB-1:0] qb;
    logic          nega;
    logic          negb;
    logic          biga;
    logic          bigb;
    logic          zero;
  } qst_t;

  typedef struct packed {
    logic [OW-1:0] val;
    logic          sat;
  } res_t;

  function automatic res_t clip(input logic [QB-1:0] q, input logic neg, input logic big);
    res_t          r;
    logic [QB-1:0] lim;
    lim   = neg ? (QB'(1) << (OW - 1)) : ((QB'(1) << (OW - 1)) - QB'(1));
    r.sat = big || (q > lim);
    if (r.sat) begin
      r.val = neg ? tebe_pkg::OUT_MIN : tebe_pkg::OUT_MAX;
    end else begin
      r.val = neg ? -q[OW-1:0] : q[OW-1:0];
    end
    return r;
  endfunction

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  assign en[NS]   = out_ready;
  assign in_ready = en[0];

  for (genvar g = 0; g < NS; g++) begin : g_en
    assign en[g] = !v_r[g] || en[g+1];
  end

  // stage M: signed length times the point offsets
  logic signed [LW-1:0] len_c;
  logic signed [LW-1:0] len_m_r;
  logic signed [PW-1:0] pa_m_r, pb_m_r;
  logic signed [AW-1:0] area_m_r;
  logic                 cmd_m_r, zero_m_r;

  assign len_c = in_lneg ? -$signed({1'b0, in_root}) : $signed({1'b0, in_root});

  // stage A: numerators and magnitudes
  logic signed [NW:0]   lx_c, pax_c, pbx_c, numa_c, numb_c;
  logic [NW-1:0]        na_r, nb_r;
  logic [AW-1:0]        dm_r;
  logic                 nega_r, negb_r, zero_a_r;

  assign lx_c   = (NW+1)'(len_m_r) <<< (2 * FB);
  assign pax_c  = (NW+1)'(pa_m_r) <<< FB;
  assign pbx_c  = (NW+1)'(pb_m_r) <<< FB;
  assign numa_c = (cmd_m_r == tebe_pkg::CMD_CURL) ? -lx_c : pax_c;
  assign numb_c = (cmd_m_r == tebe_pkg::CMD_CURL) ? lx_c : pbx_c;

  // stage B: rounding offsets
  logic [XW-1:0]        nna_r, nnb_r, dd_r;
  logic                 nega_b_r, negb_b_r, zero_b_r;

  // stage C and the quotient stages
  qst_t                 qc_nxt;
  qst_t                 q_r   [QB+1];
  qst_t                 q_nxt [QB+1];

  always_comb begin
    qc_nxt      = '0;
    qc_nxt.ra   = nna_r;
    qc_nxt.rb   = nnb_r;
    qc_nxt.d    = dd_r;
    qc_nxt.nega = nega_b_r;
    qc_nxt.negb = negb_b_r;
    qc_nxt.zero = zero_b_r;
    qc_nxt.biga = nna_r >= (dd_r << QB);
    qc_nxt.bigb = nnb_r >= (dd_r << QB);
  end

  assign q_nxt[0] = qc_nxt;

  for (genvar g = 0; g < QB; g++) begin : g_q
    localparam int B = QB - 1 - g;
    logic [XW-1:0] t;
    logic          ga, gb;

    assign t  = q_r[g].d << B;
    assign ga = q_r[g].ra >= t;
    assign gb = q_r[g].rb >= t;

    always_comb begin
      q_nxt[g+1] = q_r[g];
      if (ga) begin
        q_nxt[g+1].ra = q_r[g].ra - t;
        q_nxt[g+1].qa = q_r[g].qa | (QB'(1) << B);
      end
      if (gb) begin
        q_nxt[g+1].rb = q_r[g].rb - t;
        q_nxt[g+1].qb = q_r[g].qb | (QB'(1) << B);
      end
    end
  end

  // stage F: clip and register the result
  res_t                 ra_c, rb_c;
  logic [OW-1:0]        first_r, second_r;
  logic                 degen_r, sat_r;

  assign ra_c = clip(q_r[QB].qa, q_r[QB].nega, q_r[QB].biga);
  assign rb_c = clip(q_r[QB].qb, q_r[QB].negb, q_r[QB].bigb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[SM]) v_r[SM] <= in_valid;
      for (int i = SA; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SM]) begin
      len_m_r  <= len_c;
      pa_m_r   <= len_c * in_ey;
      pb_m_r   <= len_c * in_ex;
      area_m_r <= in_area;
      cmd_m_r  <= in_cmd;
      zero_m_r <= in_zero;
    end
    if (en[SA]) begin
      na_r     <= numa_c[NW] ? NW'(-numa_c) : NW'(numa_c);
      nb_r     <= numb_c[NW] ? NW'(-numb_c) : NW'(numb_c);
      dm_r     <= area_m_r[AW-1] ? AW'(-area_m_r) : AW'(area_m_r);
      nega_r   <= numa_c[NW] ^ area_m_r[AW-1];
      negb_r   <= numb_c[NW] ^ area_m_r[AW-1];
      zero_a_r <= zero_m_r;
    end
    if (en[SB]) begin
      nna_r    <= (XW'(na_r) << 1) + XW'(dm_r);
      nnb_r    <= (XW'(nb_r) << 1) + XW'(dm_r);
      dd_r     <= XW'(dm_r) << 1;
      nega_b_r <= nega_r;
      negb_b_r <= negb_r;
      zero_b_r <= zero_a_r;
    end
    for (int i = 0; i <= QB; i++) begin
      if (en[SC+i]) q_r[i] <= q_nxt[i];
    end
    if (en[SF]) begin
      degen_r  <= q_r[QB].zero;
      first_r  <= q_r[QB].zero ? '0 : ra_c.val;
      second_r <= q_r[QB].zero ? '0 : rb_c.val;
      sat_r    <= !q_r[QB].zero && (ra_c.sat || rb_c.sat);
    end
  end

  assign out_valid  = v_r[SF];
  assign out_first  = signed'(first_r);
  assign out_second = signed'(second_r);
  assign out_degen  = degen_r;
  assign out_sat    = sat_r;
endmodule

@@ sv/triangle_edge_basis_eval_unit.sv @@
// Edge basis evaluation unit: lowest-order edge element on a triangle.
// Active-low synchronous reset clears only the valid bits. Stages in order:
//   3 front stages, COORD_BITS + 1 square root stages, 38 scale/divide stages.
// Throughput: one beat per cycle unless the result side stalls; a stage
//   advances when it is empty or its successor advances.
module triangle_edge_basis_eval_unit #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic          clk,
  input logic          rst_n,
  tebe_in_if.sink      in_chan,
  tebe_out_if.source   out_chan
);
  localparam int DW = COORD_BITS + 1;
  localparam int AW = 2 * DW + 1;
  localparam int SW = 2 * COORD_BITS + 2;
  localparam int RW = COORD_BITS + 1;

  typedef struct packed {
    logic                 cmd;
    logic                 zero;
    logic                 lneg;
    logic signed [DW-1:0] ex;
    logic signed [DW-1:0] ey;
    logic signed [AW-1:0] area;
  } side_t;

  logic          f_valid, f_ready;
  side_t         f_side, q_side;
  logic [SW-1:0] f_s;
  logic          q_valid, q_ready;
  logic [RW-1:0] q_root;

  tebe_front #(.CB(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_cmd    (in_chan.command),
    .in_edge   (in_chan.edge_req),
    .in_px     (in_chan.px),
    .in_py     (in_chan.py),
    .in_ax     (in_chan.ax),
    .in_ay     (in_chan.ay),
    .in_bx     (in_chan.bx),
    .in_by     (in_chan.by),
    .in_cx     (in_chan.cx),
    .in_cy     (in_chan.cy),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_cmd   (f_side.cmd),
    .out_zero  (f_side.zero),
    .out_lneg  (f_side.lneg),
    .out_ex    (f_side.ex),
    .out_ey    (f_side.ey),
    .out_area  (f_side.area),
    .out_s     (f_s)
  );

  tebe_sqrt #(.CB(COORD_BITS), .SIDE_W($bits(side_t))) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_s      (f_s),
    .in_side   (f_side),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  tebe_div #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_root    (q_root),
    .in_lneg    (q_side.lneg),
    .in_cmd     (q_side.cmd),
    .in_zero    (q_side.zero),
    .in_ex      (q_side.ex),
    .in_ey      (q_side.ey),
    .in_area    (q_side.area),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_first  (out_chan.out_first),
    .out_second (out_chan.out_second),
    .out_degen  (out_chan.degenerate),
    .out_sat    (out_chan.saturated)
  );
endmodule

@@ sv/tebe_chk.sv @@
// Port-level checker for the edge basis evaluation unit, bound to the top.
// Depends on tebe_pkg and the assertion macro header.
`include "triangle_edge_basis_eval_unit_macros.svh"

module tebe_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tebe_pkg::OUT_W-1:0]  out_first,
  input logic [tebe_pkg::OUT_W-1:0]  out_second,
  input logic                        degenerate,
  input logic                        saturated
);
  `TEBE_ASSERT_IMPL(a_degen_zero, out_valid && degenerate, out_first == '0 && out_second == '0 && !saturated)
  `TEBE_ASSERT_IMPL(a_sat_clipped, out_valid && saturated, out_first == tebe_pkg::OUT_MAX || out_first == tebe_pkg::OUT_MIN || out_second == tebe_pkg::OUT_MAX || out_second == tebe_pkg::OUT_MIN)
  `TEBE_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(out_first) && $stable(out_second) && $stable(degenerate) && $stable(saturated))
  `TEBE_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)
endmodule

bind triangle_edge_basis_eval_unit tebe_chk u_tebe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_first  (out_chan.out_first),
  .out_second (out_chan.out_second),
  .degenerate (out_chan.degenerate),
  .saturated  (out_chan.saturated)
);

@@ sim/tb.sv @@
// Testbench for triangle_edge_basis_eval_unit: directed and random beats with
// a built-in predictor of the edge basis value and curl, checked beat by beat.
// Depends on tebe_pkg, tebe_if and the unit itself.
`timescale 1ns / 100ps

module tb;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] uwide_t;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    logic        degen;
    logic        sat;
  } basis_result_t;

  localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] ONE   = 32'h0001_0000;
  localparam int FRAC_W = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tebe_in_if  in_chan();
  tebe_out_if out_chan();

  triangle_edge_basis_eval_unit uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  basis_result_t expected_q[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned n_degen = 0;
  int unsigned n_sat = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int unsigned rx_hold = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  function automatic wide_t sx(logic [31:0] v);
    return {{160{v[31]}}, v};
  endfunction

  function automatic wide_t wabs(wide_t v);
    return v[191] ? -v : v;
  endfunction

  // num/den rounded to nearest, ties away from zero, clipped to 32 bits
  function automatic logic [31:0] round_div(wide_t num, wide_t den, inout logic sat);
    logic   neg;
    uwide_t n, d, q, lim;
    neg = num[191] ^ den[191];
    n = wabs(num);
    d = wabs(den);
    q = (2 * n + d) / (2 * d);
    lim = neg ? uwide_t'(64'h8000_0000) : uwide_t'(64'h7FFF_FFFF);
    if (q > lim) begin
      sat = 1'b1;
      return neg ? tebe_pkg::OUT_MIN : tebe_pkg::OUT_MAX;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic basis_result_t eval_basis(logic cmd, logic [1:0] edge_sel,
      logic [31:0] px, py, ax, ay, bx, by, cx, cy);
    basis_result_t res;
    wide_t  vx[3], vy[3], area, l0, l1, s, sc;
    uwide_t len, t;
    int     e, j, k;
    vx[0] = sx(ax); vy[0] = sx(ay);
    vx[1] = sx(bx); vy[1] = sx(by);
    vx[2] = sx(cx); vy[2] = sx(cy);
    e = (edge_sel == 2'd3) ? 0 : int'(edge_sel);
    j = (e + 1) % 3;
    k = (e + 2) % 3;
    res = '{first: '0, second: '0, degen: 1'b0, sat: 1'b0};
    area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
    if (area == 0) begin
      res.degen = 1'b1;
      return res;
    end
    l0 = vx[j] - vx[k];
    l1 = vy[j] - vy[k];
    s = l0 * l0 + l1 * l1;
    len = '0;
    for (int b = 61; b >= 0; b--) begin
      t = len | (uwide_t'(1) << b);
      if (t * t <= uwide_t'(s)) len = t;
    end
    sc = wide_t'(len);
    if (wabs(l0) > wabs(l1)) begin
      if (l0[191]) sc = -sc;
    end else begin
      if (l1[191]) sc = -sc;
    end
    if (cmd == tebe_pkg::CMD_VALUE) begin
      sc = sc <<< FRAC_W;
      res.first  = round_div(sc * (vy[e] - sx(py)), area, res.sat);
      res.second = round_div(sc * (sx(px) - vx[e]), area, res.sat);
    end else begin
      sc = sc <<< (2 * FRAC_W);
      res.first  = round_div(-sc, area, res.sat);
      res.second = round_div(sc, area, res.sat);
    end
    return res;
  endfunction

  task automatic send_item(logic cmd, logic [1:0] edge_sel,
      logic [31:0] px, py, ax, ay, bx, by, cx, cy);
    int unsigned gap;
    basis_result_t r;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.command  <= cmd;
    in_chan.edge_req <= edge_sel;
    in_chan.px <= px; in_chan.py <= py;
    in_chan.ax <= ax; in_chan.ay <= ay;
    in_chan.bx <= bx; in_chan.by <= by;
    in_chan.cx <= cx; in_chan.cy <= cy;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    r = eval_basis(cmd, edge_sel, px, py, ax, ay, bx, by, cx, cy);
    n_degen += r.degen;
    n_sat += r.sat;
    expected_q.push_back(r);
    sent++;
  endtask

  task automatic send_random(int unsigned kind);
    logic [31:0] c0, c1, dx, dy, p[8];
    int unsigned span;
    for (int i = 0; i < 8; i++) p[i] = $urandom;
    case (kind)
      0: ;
      1, 2: begin
        // small triangle near a random point, point inside or close by
        span = (kind == 1) ? 20 : 8;
        c0 = $urandom; c1 = $urandom;
        for (int i = 0; i < 8; i += 2) begin
          p[i]   = c0 + ($urandom & ((32'd1 << span) - 1)) - (32'd1 << (span - 1));
          p[i+1] = c1 + ($urandom & ((32'd1 << span) - 1)) - (32'd1 << (span - 1));
        end
      end
      default: begin
        // collinear vertices
        dx = $urandom_range(0, 65535) - 32768;
        dy = $urandom_range(0, 65535) - 32768;
        p[4] = p[2] + dx;        p[5] = p[3] + dy;
        p[6] = p[2] + 2 * dx;    p[7] = p[3] + 2 * dy;
      end
    endcase
    send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
              p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
  endtask

  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
  endtask

  task automatic test_directed();
    for (int e = 0; e < 3; e++) begin
      send_item(tebe_pkg::CMD_VALUE, 2'(e), C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN,
                C_MIN, C_MAX);
      send_item(tebe_pkg::CMD_CURL, 2'(e), C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                C_MIN, C_MAX);
      send_item(tebe_pkg::CMD_VALUE, 2'(e), ONE / 4, ONE / 4, 0, 0, ONE, 0, 0, ONE);
    end
    send_item(tebe_pkg::CMD_VALUE, tebe_pkg::EDGE_12, C_MAX, C_MIN, 0, 0, 0, 0, 0, 0);
    send_item(tebe_pkg::CMD_CURL, tebe_pkg::EDGE_20, 5, 7, ONE, ONE, 2 * ONE, 3 * ONE,
              3 * ONE, 5 * ONE);
    send_item(tebe_pkg::CMD_VALUE, 2'd3, ONE, ONE, 0, 0, 2 * ONE, 0, 0, 3 * ONE);
    send_item(tebe_pkg::CMD_CURL, 2'd3, ONE, ONE, 0, 0, 2 * ONE, 0, 0, 3 * ONE);
    send_item(tebe_pkg::CMD_VALUE, tebe_pkg::EDGE_01, C_MAX, C_MIN, 0, 0, 1, 0, 0, 1);
    send_item(tebe_pkg::CMD_CURL, tebe_pkg::EDGE_01, 0, 0, 0, 0, 1, 0, 0, 1);
    // equal magnitudes in x and y, y decides the sign
    send_item(tebe_pkg::CMD_VALUE, tebe_pkg::EDGE_01, ONE, 0, 0, 0, ONE, ONE, 0, ONE * 2);
    send_item(tebe_pkg::CMD_CURL, tebe_pkg::EDGE_01, ONE, 0, 0, 0, ONE, ONE, 0, ONE * 2);
    send_item(tebe_pkg::CMD_VALUE, tebe_pkg::EDGE_12, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN,
              C_MAX, C_MAX, C_MIN);
  endtask

  task automatic test_random(int unsigned n, bit txg, bit rxg);
    tx_gaps = txg;
    rx_gaps = rxg;
    repeat (n) send_random($urandom_range(0, 9) < 2 ? 0 :
                           $urandom_range(0, 9) < 8 ? $urandom_range(1, 2) : 3);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold = 400;
    repeat (150) send_random($urandom_range(1, 3));
    tx_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (30) send_random($urandom_range(0, 3));
    wait_drain();
    repeat (30) send_random($urandom_range(0, 3));
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned w;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      w = rx_gaps ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
        out_chan.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    basis_result_t x;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat first=%h second=%h", $time,
                 out_chan.out_first, out_chan.out_second);
        errors++;
      end else begin
        x = expected_q.pop_front();
        checked++;
        if (out_chan.out_first !== x.first) begin
          $display("%0t: out_first exp %h got %h", $time, x.first, out_chan.out_first);
          errors++;
        end
        if (out_chan.out_second !== x.second) begin
          $display("%0t: out_second exp %h got %h", $time, x.second, out_chan.out_second);
          errors++;
        end
        if (out_chan.degenerate !== x.degen) begin
          $display("%0t: degenerate exp %b got %b", $time, x.degen, out_chan.degenerate);
          errors++;
        end
        if (out_chan.saturated !== x.sat) begin
          $display("%0t: saturated exp %b got %b", $time, x.sat, out_chan.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.command <= tebe_pkg::CMD_VALUE;
    in_chan.edge_req <= tebe_pkg::EDGE_12;
    in_chan.px <= '0; in_chan.py <= '0;
    in_chan.ax <= '0; in_chan.ay <= '0;
    in_chan.bx <= '0; in_chan.by <= '0;
    in_chan.cx <= '0; in_chan.cy <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600, 1'b1, 1'b1);
    test_backpressure();
    test_random(400, 1'b0, 1'b0);
    test_drain_pause();
    test_random(400, 1'b0, 1'b1);
    test_random(100, 1'b1, 1'b0);
    wait_drain();
    repeat (120) @(posedge clk);
    $display("tb: %0d beats sent, %0d checked (%0d degenerate, %0d clipped)",
             sent, checked, n_degen, n_sat);
    $display("tb: value and curl on all edges, stalls on both sides, long hold-off");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
